// ===== rtl/sorted_timer_expiry_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted timer expiry queue assertion macros
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_EXPIRY_QUEUE_MACROS_SVH
`define SORTED_TIMER_EXPIRY_QUEUE_MACROS_SVH
`ifndef SYNTH
`define STQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stq: same-cycle check failed");
`define STQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stq: next-cycle check failed");
`else
`define STQ_ASSERT_NOW(lbl, ante, cons)
`define STQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted timer expiry queue package
// Request and status codes, field widths and the types shared by the cells.
// ----------------------------------------------------------------------------
package stq_pkg;

	// field widths
	localparam int ID_W  = 4;
	localparam int TAG_W = 8;
	localparam int ARG_W = 32;
	localparam int CFG_W = 32;

	// request codes
	localparam logic [1:0] REQ_ADD  = 2'd0;
	localparam logic [1:0] REQ_DEL  = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	// add status codes
	localparam logic [1:0] ADD_OK    = 2'd0;
	localparam logic [1:0] ADD_LIMIT = 2'd1;
	localparam logic [1:0] ADD_FULL  = 2'd2;
	localparam logic [1:0] ADD_DUP   = 2'd3;

	// result kinds
	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	// register index of the timeout limit
	localparam logic REG_TMO_LIMIT = 1'b0;

	// expiry reports per tick are capped
	localparam int MAX_REPORTS  = 16;
	localparam int REPORT_CNT_W = 5;

	// data carried along with the timeout
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [TAG_W-1:0] tag;
		logic [ARG_W-1:0] arg;
	} payload_t;

	// per-cell move command
	typedef struct packed {
		logic ins;  // insert key at the sorted position
		logic shl;  // take the right neighbor's entry
	} cell_ctl_t;

endpackage

// ===== rtl/stq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted timer expiry queue cell
// One slot of the sorted chain: holds an entry, compares it with the broadcast
// key and id, and moves toward either neighbor on command.
// ----------------------------------------------------------------------------
module stq_cell #(
	parameter int TIME_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stq_pkg::cell_ctl_t           ctl,
	input  logic [TIME_BITS-1:0]         key,
	input  logic [stq_pkg::ID_W-1:0]     key_id,
	input  stq_pkg::payload_t            new_pay,
	input  logic                         prev_valid,
	input  logic                         prev_le,
	input  logic [TIME_BITS-1:0]         prev_time,
	input  stq_pkg::payload_t            prev_pay,
	input  logic                         next_valid,
	input  logic [TIME_BITS-1:0]         next_time,
	input  stq_pkg::payload_t            next_pay,
	output logic                         valid,
	output logic [TIME_BITS-1:0]         cell_time,
	output stq_pkg::payload_t            pay,
	output logic                         le,
	output logic                         id_hit
);

	logic                 valid_q, valid_d;
	logic [TIME_BITS-1:0] time_q, time_d;
	stq_pkg::payload_t    pay_q, pay_d;

	// compare the held entry with the broadcast key and id
	assign le     = valid_q && (time_q <= key);
	assign id_hit = valid_q && (pay_q.id == key_id);

	// pick the next content: hold, shift left, or make room for an insert
	always_comb begin
		valid_d = valid_q;
		time_d  = time_q;
		pay_d   = pay_q;
		if (ctl.shl) begin
			valid_d = next_valid;
			time_d  = next_time;
			pay_d   = next_pay;
		end else if (ctl.ins && !le) begin
			if (prev_le) begin
				valid_d = 1'b1;
				time_d  = key;
				pay_d   = new_pay;
			end else begin
				valid_d = prev_valid;
				time_d  = prev_time;
				pay_d   = prev_pay;
			end
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// entry data
	always_ff @(posedge clk) begin
		time_q <= time_d;
		pay_q  <= pay_d;
	end

	assign valid     = valid_q;
	assign cell_time = time_q;
	assign pay       = pay_q;

endmodule

// ===== rtl/sorted_timer_expiry_queue.sv =====
// Add and delete: the request is registered on transfer, then acts on the cell chain in the exec state.
// An add status loads the output register from the exec state, which waits while a
// stalled result still occupies that register.
// Tick: after transfer, pops each expired entry from the head cell, then closes; a reported pop or
// the close waits while a stalled result blocks it; a report is held until the next head sets its last flag.
// Reset empties every cell at once and sets the timeout limit to all ones; no clear pass.
// ----------------------------------------------------------------------------
// Sorted timer expiry queue
// Chain of cells kept sorted by timeout, with a request sequencer, an APB
// register port and a registered result channel.
// ----------------------------------------------------------------------------
module sorted_timer_expiry_queue #(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [stq_pkg::CFG_W-1:0]   pwdata,
	output logic [stq_pkg::CFG_W-1:0]   prdata,
	output logic                        pready,
	// request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  req_type,
	input  logic [stq_pkg::ID_W-1:0]    timer_id,
	input  logic [31:0]                 timeout,
	input  logic [stq_pkg::TAG_W-1:0]   handler_tag,
	input  logic [stq_pkg::ARG_W-1:0]   callback_arg,
	input  logic [31:0]                 current_time,
	// result channel
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        result_kind,
	output logic [1:0]                  add_status,
	output logic [stq_pkg::ID_W-1:0]    expired_id,
	output logic [stq_pkg::TAG_W-1:0]   expired_tag,
	output logic [stq_pkg::ARG_W-1:0]   expired_arg,
	output logic                        last
);

	`include "sorted_timer_expiry_queue_macros.svh"

	localparam int CmpW = (TIME_BITS > stq_pkg::CFG_W) ? TIME_BITS : stq_pkg::CFG_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_TICK = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [stq_pkg::CFG_W-1:0] tmo_limit_q;

	// request register
	logic [1:0]               req_type_q;
	logic [stq_pkg::ID_W-1:0] id_q;
	logic [TIME_BITS-1:0]     key_q;
	stq_pkg::payload_t        new_pay_q;
	logic                     over_q;

	logic                 req_go;
	logic [TIME_BITS-1:0] tmo_key;
	logic [TIME_BITS-1:0] now_key;

	// cell chain
	logic [SLOTS-1:0]     occ, le_v, hit_v, del_seen;
	logic [TIME_BITS-1:0] time_a [SLOTS];
	stq_pkg::payload_t    pay_a [SLOTS];
	stq_pkg::cell_ctl_t   ctl_a [SLOTS];

	// sequencer controls
	logic       ins, pop, del_go;
	logic [1:0] add_code;
	logic       head_exp, head_rep;
	logic       pend_load, pend_clr, cnt_inc;

	// holding stage for the latest report of a tick
	logic                              pend_valid_q;
	stq_pkg::payload_t                 pend_pay_q;
	logic [stq_pkg::REPORT_CNT_W-1:0]  rep_cnt_q;

	// output register
	logic              out_valid_q, out_free, out_load;
	logic              out_kind_d, out_kind_q;
	logic [1:0]        out_status_d, out_status_q;
	stq_pkg::payload_t out_pay_d, out_pay_q;
	logic              out_last_d, out_last_q;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == stq_pkg::REG_TMO_LIMIT) ? tmo_limit_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_limit_q <= '1;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == stq_pkg::REG_TMO_LIMIT)) begin
			tmo_limit_q <= pwdata;
		end
	end

	// request transfer
	assign req_stall = (state_q != ST_IDLE);
	assign req_go    = req_valid && !req_stall;
	assign tmo_key   = TIME_BITS'(timeout);
	assign now_key   = TIME_BITS'(current_time);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_type_q <= stq_pkg::REQ_ADD;
		end else if (req_go) begin
			req_type_q <= req_type;
		end
	end

	always_ff @(posedge clk) begin
		if (req_go) begin
			id_q          <= timer_id;
			key_q         <= (req_type == stq_pkg::REQ_TICK) ? now_key : tmo_key;
			new_pay_q.id  <= timer_id;
			new_pay_q.tag <= handler_tag;
			new_pay_q.arg <= callback_arg;
			over_q        <= CmpW'(tmo_key) > CmpW'(tmo_limit_q);
		end
	end

	// build the chain
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic                 p_valid, p_le, n_valid;
		logic [TIME_BITS-1:0] p_time, n_time;
		stq_pkg::payload_t    p_pay, n_pay;

		if (i == 0) begin : g_head
			assign p_valid = 1'b0;
			assign p_le    = 1'b1;
			assign p_time  = '0;
			assign p_pay   = '0;
		end else begin : g_body
			assign p_valid = occ[i-1];
			assign p_le    = le_v[i-1];
			assign p_time  = time_a[i-1];
			assign p_pay   = pay_a[i-1];
		end

		if (i == SLOTS - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_time  = '0;
			assign n_pay   = '0;
		end else begin : g_inner
			assign n_valid = occ[i+1];
			assign n_time  = time_a[i+1];
			assign n_pay   = pay_a[i+1];
		end

		stq_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl_a[i]),
			.key        (key_q),
			.key_id     (id_q),
			.new_pay    (new_pay_q),
			.prev_valid (p_valid),
			.prev_le    (p_le),
			.prev_time  (p_time),
			.prev_pay   (p_pay),
			.next_valid (n_valid),
			.next_time  (n_time),
			.next_pay   (n_pay),
			.valid      (occ[i]),
			.cell_time  (time_a[i]),
			.pay        (pay_a[i]),
			.le         (le_v[i]),
			.id_hit     (hit_v[i])
		);
	end

	// ids are unique, so the hit is one-hot: shift every cell at and past it
	assign del_seen = (hit_v == '0) ? '0 : ~(hit_v - SLOTS'(1));

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			ctl_a[i].ins = ins;
			ctl_a[i].shl = pop || (del_go && del_seen[i]);
		end
	end

	// add checks in priority order: limit, full, duplicate
	always_comb begin
		if (over_q) begin
			add_code = stq_pkg::ADD_LIMIT;
		end else if (occ[SLOTS-1]) begin
			add_code = stq_pkg::ADD_FULL;
		end else if (|hit_v) begin
			add_code = stq_pkg::ADD_DUP;
		end else begin
			add_code = stq_pkg::ADD_OK;
		end
	end

	assign out_free = !out_valid_q || !rsp_stall;
	assign head_exp = le_v[0];
	assign head_rep = head_exp && (pay_a[0].tag != '0)
		&& (rep_cnt_q < stq_pkg::REPORT_CNT_W'(stq_pkg::MAX_REPORTS));

	// sequencer
	always_comb begin
		state_d      = state_q;
		ins          = 1'b0;
		pop          = 1'b0;
		del_go       = 1'b0;
		pend_load    = 1'b0;
		pend_clr     = 1'b0;
		cnt_inc      = 1'b0;
		out_load     = 1'b0;
		out_kind_d   = stq_pkg::KIND_ADD;
		out_status_d = stq_pkg::ADD_OK;
		out_pay_d    = '0;
		out_last_d   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_go) begin
					case (req_type)
						stq_pkg::REQ_ADD, stq_pkg::REQ_DEL: state_d = ST_EXEC;
						stq_pkg::REQ_TICK:                  state_d = ST_TICK;
						default:                            state_d = ST_IDLE;
					endcase
				end
			end
			ST_EXEC: begin
				case (req_type_q)
					stq_pkg::REQ_ADD: begin
						if (out_free) begin
							out_load     = 1'b1;
							out_status_d = add_code;
							out_last_d   = 1'b1;
							ins          = (add_code == stq_pkg::ADD_OK);
							state_d      = ST_IDLE;
						end
					end
					stq_pkg::REQ_DEL: begin
						del_go  = 1'b1;
						state_d = ST_IDLE;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_TICK: begin
				if (head_exp) begin
					if (!head_rep) begin
						// drop silently
						pop = 1'b1;
					end else if (!pend_valid_q || out_free) begin
						// a newer report exists, so the held one is not the last
						pop       = 1'b1;
						pend_load = 1'b1;
						cnt_inc   = 1'b1;
						if (pend_valid_q) begin
							out_load   = 1'b1;
							out_kind_d = stq_pkg::KIND_EXPIRY;
							out_pay_d  = pend_pay_q;
						end
					end
				end else if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					// head not expired: the held report closes the tick
					out_load   = 1'b1;
					out_kind_d = stq_pkg::KIND_EXPIRY;
					out_pay_d  = pend_pay_q;
					out_last_d = 1'b1;
					pend_clr   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			rep_cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clr) begin
				pend_valid_q <= 1'b0;
			end
			if (req_go) begin
				rep_cnt_q <= '0;
			end else if (cnt_inc) begin
				rep_cnt_q <= rep_cnt_q + stq_pkg::REPORT_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_pay_q <= pay_a[0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q   <= out_kind_d;
			out_status_q <= out_status_d;
			out_pay_q    <= out_pay_d;
			out_last_q   <= out_last_d;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign add_status  = out_status_q;
	assign expired_id  = out_pay_q.id;
	assign expired_tag = out_pay_q.tag;
	assign expired_arg = out_pay_q.arg;
	assign last        = out_last_q;

	// checks
	`STQ_ASSERT_NOW(a_occ_contiguous, 1'b1, ((occ + SLOTS'(1)) & occ) == '0)
	`STQ_ASSERT_NOW(a_pend_in_tick, pend_valid_q, state_q == ST_TICK)
	`STQ_ASSERT_NOW(a_ins_has_room, ins, !occ[SLOTS-1])
	`STQ_ASSERT_NOW(a_report_tag, rsp_valid && (result_kind == stq_pkg::KIND_EXPIRY), expired_tag != '0)
	`STQ_ASSERT_NXT(a_add_answers, (state_q == ST_EXEC) && (req_type_q == stq_pkg::REQ_ADD) && out_free, rsp_valid && last)

endmodule
